// ----- design/fcos_pkg.sv -----
// ----------------------------------------------------------------------------
// fcos_pkg
// shared types and constants of the flash chip operation scheduler
// ----------------------------------------------------------------------------
package fcos_pkg;

    localparam int CHIPS       = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int CHIP_W      = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = PTR_W + 1;
    localparam int LAT_W       = 20;
    localparam int LIM_W       = 5;
    localparam int TAG_W       = 16;
    localparam int OP_W        = 2;
    localparam int TIME_W      = 32;
    localparam int ENTRY_W     = OP_W + TAG_W;

    localparam logic [1:0] REG_READ_LAT  = 2'd0;
    localparam logic [1:0] REG_PROG_LAT  = 2'd1;
    localparam logic [1:0] REG_ERASE_LAT = 2'd2;
    localparam logic [1:0] REG_QLIMIT    = 2'd3;

    localparam logic [OP_W-1:0] OP_READ    = 2'd0;
    localparam logic [OP_W-1:0] OP_PROGRAM = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE   = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD     = 2'd3;

    localparam logic [1:0] EV_ACCEPTED = 2'd0;
    localparam logic [1:0] EV_REJECTED = 2'd1;
    localparam logic [1:0] EV_STARTED  = 2'd2;
    localparam logic [1:0] EV_FINISHED = 2'd3;

    localparam logic KIND_ISSUE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_FIN,
        S_START,
        S_READ,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic              latch;
        logic              now_inc;
        logic              issue_do;
        logic              emit_fin;
        logic              rd_req;
        logic              emit_start;
        logic              flush;
        logic [CHIP_W-1:0] chip;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic fin_hit;
        logic start_hit;
        logic emit_ok;
        logic pend_v;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [1:0]        ev;
        logic [CHIP_W-1:0] chip;
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] ts;
    } t_event;

endpackage

// ----- design/fcos_if.sv -----
// ----------------------------------------------------------------------------
// fcos_if
// valid/ready channels of the scheduler: items, results and register writes
// ----------------------------------------------------------------------------
interface fcos_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [fcos_pkg::CHIP_W-1:0] chip;
    logic [fcos_pkg::OP_W-1:0] operation;
    logic [fcos_pkg::TAG_W-1:0] tag;
    modport source (output valid, kind, chip, operation, tag, input ready);
    modport sink (input valid, kind, chip, operation, tag, output ready);
endinterface

interface fcos_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  event_res;
    logic [fcos_pkg::CHIP_W-1:0] chip_out;
    logic [fcos_pkg::OP_W-1:0]   operation_out;
    logic [fcos_pkg::TAG_W-1:0]  tag_out;
    logic [fcos_pkg::TIME_W-1:0] time_stamp;
    logic                        last;
    modport source (output valid, event_res, chip_out, operation_out, tag_out,
                    time_stamp, last, input ready);
    modport sink (input valid, event_res, chip_out, operation_out, tag_out,
                  time_stamp, last, output ready);
endinterface

interface fcos_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 index;
    logic [fcos_pkg::LAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/fcos_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcos_ctrl
// sequencer: issue handling and the two chip scans of a tick
// ----------------------------------------------------------------------------
module fcos_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fcos_pkg::t_status i_status,
    output fcos_pkg::t_cmd    o_cmd
);

    fcos_pkg::t_state                r_state, n_state;
    logic [fcos_pkg::CHIP_W-1:0]     r_chip, n_chip;
    logic                            last_chip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcos_pkg::S_IDLE;
            r_chip  <= '0;
        end else begin
            r_state <= n_state;
            r_chip  <= n_chip;
        end
    end

    assign last_chip = (r_chip == fcos_pkg::CHIP_W'(fcos_pkg::CHIPS - 1));

    always_comb begin
        n_state    = r_state;
        n_chip     = r_chip;
        o_cmd      = '0;
        o_cmd.chip = r_chip;
        o_in_ready = 1'b0;
        unique case (r_state)
            fcos_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_chip      = '0;
                    n_state     = fcos_pkg::S_ISSUE;
                end
            end
            fcos_pkg::S_ISSUE: begin
                if (i_status.kind == fcos_pkg::KIND_TICK) begin
                    o_cmd.now_inc = 1'b1;
                    n_state       = fcos_pkg::S_FIN;
                end else if (i_status.out_free) begin
                    o_cmd.issue_do = 1'b1;
                    n_state        = fcos_pkg::S_IDLE;
                end
            end
            fcos_pkg::S_FIN: begin
                if (!i_status.fin_hit || i_status.emit_ok) begin
                    o_cmd.emit_fin = i_status.fin_hit;
                    if (last_chip) begin
                        n_chip  = '0;
                        n_state = fcos_pkg::S_START;
                    end else begin
                        n_chip = r_chip + 1'b1;
                    end
                end
            end
            fcos_pkg::S_START: begin
                if (i_status.start_hit) begin
                    o_cmd.rd_req = 1'b1;
                    n_state      = fcos_pkg::S_READ;
                end else if (last_chip) begin
                    n_state = fcos_pkg::S_FLUSH;
                end else begin
                    n_chip = r_chip + 1'b1;
                end
            end
            fcos_pkg::S_READ: begin
                if (i_status.emit_ok) begin
                    o_cmd.emit_start = 1'b1;
                    if (last_chip) begin
                        n_state = fcos_pkg::S_FLUSH;
                    end else begin
                        n_chip  = r_chip + 1'b1;
                        n_state = fcos_pkg::S_START;
                    end
                end
            end
            fcos_pkg::S_FLUSH: begin
                if (!i_status.pend_v) begin
                    n_state = fcos_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = fcos_pkg::S_IDLE;
                end
            end
            default: n_state = fcos_pkg::S_IDLE;
        endcase
    end

endmodule

// ----- design/fcos_dp.sv -----
// ----------------------------------------------------------------------------
// fcos_dp
// chip queues, busy timers, clock, registers and the result stages
// ----------------------------------------------------------------------------
module fcos_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fcos_in_if.sink           i_in,
    fcos_out_if.source        o_out,
    fcos_cfg_if.sink          i_cfg,
    input  fcos_pkg::t_cmd    i_cmd,
    output fcos_pkg::t_status o_status
);

    localparam int CHIPS = fcos_pkg::CHIPS;
    localparam int QD    = fcos_pkg::QUEUE_DEPTH;
    localparam int AW    = fcos_pkg::CHIP_W + fcos_pkg::PTR_W;

    logic [fcos_pkg::ENTRY_W-1:0] mem [CHIPS*QD];

    logic [fcos_pkg::LAT_W-1:0]  r_lat_rd, r_lat_pg, r_lat_er;
    logic [fcos_pkg::LIM_W-1:0]  r_qlim;
    logic [fcos_pkg::TIME_W-1:0] r_now;
    logic [fcos_pkg::PTR_W-1:0]  r_wp [CHIPS];
    logic [fcos_pkg::PTR_W-1:0]  r_rp [CHIPS];
    logic [fcos_pkg::FILL_W-1:0] r_fill [CHIPS];
    logic [CHIPS-1:0]            r_busy;
    logic [fcos_pkg::TIME_W-1:0] r_wake [CHIPS];
    logic [fcos_pkg::ENTRY_W-1:0] r_act [CHIPS];
    logic [fcos_pkg::ENTRY_W-1:0] r_rd;

    logic                         r_kind;
    logic [fcos_pkg::CHIP_W-1:0]  r_ichip;
    logic [fcos_pkg::OP_W-1:0]    r_iop;
    logic [fcos_pkg::TAG_W-1:0]   r_itag;

    fcos_pkg::t_event r_pend, r_out;
    logic             r_pend_v, r_out_v, r_out_last;

    logic [fcos_pkg::CHIP_W-1:0]  c;
    logic [fcos_pkg::TIME_W-1:0]  since;
    logic [fcos_pkg::FILL_W-1:0]  lim;
    logic                         reject;
    logic                         out_free;
    logic [fcos_pkg::LAT_W-1:0]   lat;
    fcos_pkg::t_event             new_ev, iss_ev;

    assign c        = i_cmd.chip;
    assign since    = r_now - r_wake[c];
    assign out_free = !r_out_v || o_out.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_qlim == '0) begin
            lim = fcos_pkg::FILL_W'(1);
        end else if (32'(r_qlim) > QD) begin
            lim = fcos_pkg::FILL_W'(QD);
        end else begin
            lim = fcos_pkg::FILL_W'(r_qlim);
        end
    end

    assign reject = (32'(r_ichip) >= CHIPS) || (r_iop == fcos_pkg::OP_BAD)
                    || (r_fill[r_ichip] >= lim);

    always_comb begin
        case (r_rd[fcos_pkg::ENTRY_W-1 -: fcos_pkg::OP_W])
            fcos_pkg::OP_READ:    lat = r_lat_rd;
            fcos_pkg::OP_PROGRAM: lat = r_lat_pg;
            default:              lat = r_lat_er;
        endcase
    end

    always_comb begin
        new_ev.chip = c;
        new_ev.ts   = r_now;
        if (i_cmd.emit_fin) begin
            new_ev.ev  = fcos_pkg::EV_FINISHED;
            new_ev.op  = r_act[c][fcos_pkg::ENTRY_W-1 -: fcos_pkg::OP_W];
            new_ev.tag = r_act[c][fcos_pkg::TAG_W-1:0];
        end else begin
            new_ev.ev  = fcos_pkg::EV_STARTED;
            new_ev.op  = r_rd[fcos_pkg::ENTRY_W-1 -: fcos_pkg::OP_W];
            new_ev.tag = r_rd[fcos_pkg::TAG_W-1:0];
        end
        iss_ev.ev   = reject ? fcos_pkg::EV_REJECTED : fcos_pkg::EV_ACCEPTED;
        iss_ev.chip = r_ichip;
        iss_ev.op   = r_iop;
        iss_ev.tag  = r_itag;
        iss_ev.ts   = r_now;
    end

    assign o_status.kind      = r_kind;
    assign o_status.fin_hit   = r_busy[c] && !since[fcos_pkg::TIME_W-1];
    assign o_status.start_hit = !r_busy[c] && (r_fill[c] != '0);
    assign o_status.emit_ok   = !r_pend_v || out_free;
    assign o_status.pend_v    = r_pend_v;
    assign o_status.out_free  = out_free;

    // queue memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_do && !reject) begin
            mem[AW'({r_ichip, r_wp[r_ichip]})] <= {r_iop, r_itag};
        end
        if (i_cmd.rd_req) begin
            r_rd <= mem[AW'({c, r_rp[c]})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_in.kind;
            r_ichip <= i_in.chip;
            r_iop   <= i_in.operation;
            r_itag  <= i_in.tag;
        end
        if (i_cmd.emit_start) begin
            r_act[c] <= r_rd;
        end
        if (i_cmd.emit_fin || i_cmd.emit_start) begin
            r_pend <= new_ev;
        end
        if (i_cmd.issue_do) begin
            r_out      <= iss_ev;
            r_out_last <= 1'b1;
        end else if ((i_cmd.emit_fin || i_cmd.emit_start) && r_pend_v) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_rd <= fcos_pkg::LAT_W'(50);
            r_lat_pg <= fcos_pkg::LAT_W'(500);
            r_lat_er <= fcos_pkg::LAT_W'(3000);
            r_qlim   <= fcos_pkg::LIM_W'(16);
            r_now    <= '0;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            for (int i = 0; i < CHIPS; i++) begin
                r_wp[i]   <= '0;
                r_rp[i]   <= '0;
                r_fill[i] <= '0;
                r_wake[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    fcos_pkg::REG_READ_LAT:  r_lat_rd <= i_cfg.data;
                    fcos_pkg::REG_PROG_LAT:  r_lat_pg <= i_cfg.data;
                    fcos_pkg::REG_ERASE_LAT: r_lat_er <= i_cfg.data;
                    fcos_pkg::REG_QLIMIT:    r_qlim <= i_cfg.data[fcos_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.now_inc) begin
                r_now <= r_now + 1'b1;
            end
            if (i_cmd.issue_do && !reject) begin
                r_wp[r_ichip]   <= (32'(r_wp[r_ichip]) == QD - 1) ? '0
                                   : r_wp[r_ichip] + 1'b1;
                r_fill[r_ichip] <= r_fill[r_ichip] + 1'b1;
            end
            if (i_cmd.emit_fin) begin
                r_busy[c] <= 1'b0;
            end
            if (i_cmd.emit_start) begin
                r_busy[c] <= 1'b1;
                r_wake[c] <= r_now + fcos_pkg::TIME_W'(lat);
                r_rp[c]   <= (32'(r_rp[c]) == QD - 1) ? '0 : r_rp[c] + 1'b1;
                r_fill[c] <= r_fill[c] - 1'b1;
            end
            if (i_cmd.emit_fin || i_cmd.emit_start) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.issue_do || i_cmd.flush
                || ((i_cmd.emit_fin || i_cmd.emit_start) && r_pend_v)) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.event_res     = r_out.ev;
    assign o_out.chip_out      = r_out.chip;
    assign o_out.operation_out = r_out.op;
    assign o_out.tag_out       = r_out.tag;
    assign o_out.time_stamp    = r_out.ts;
    assign o_out.last          = r_out_last;

endmodule

// ----- design/flash_chip_op_scheduler.sv -----
// ----------------------------------------------------------------------------
// flash_chip_op_scheduler
// per-chip operation queues and busy timers for one flash bus
// ----------------------------------------------------------------------------
// i_in carries issue and tick items, o_out the events, i_cfg register writes
// (always ready, to be written only while the block is idle).
// An issue is latched, then gives its single event (last set) once o_out has
// drained. A tick runs a finish scan over all chips, then a start scan with
// an extra queue memory read step per started chip, then a flush step that
// releases the final event. i_in is ready only between items.
// Tick events pass through a one-entry holding stage into the output register
// so the final one can be marked last; when o_out stalls the scan waits.
// A tick that causes no event gives no transfer on o_out.
// Reset clears the clock, pointers, fill counts, busy flags, wake times,
// outputs and restores the register defaults; queue contents are not cleared.
// ----------------------------------------------------------------------------
module flash_chip_op_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcos_in_if.sink    i_in,
    fcos_out_if.source o_out,
    fcos_cfg_if.sink   i_cfg
);

    fcos_pkg::t_cmd    cmd;
    fcos_pkg::t_status status;

    fcos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fcos_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

// ----- tb/flash_chip_op_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// flash_chip_op_scheduler_test
// self-checking bench: random issue and tick traffic against a scheduler model
// ----------------------------------------------------------------------------
// Items are queued by the stimulus process and sent by a clocked driver with
// random gaps. Every accepted item is run through a model of the per-chip
// queues and busy timers, which lists the events due. A clocked monitor with
// random stalls checks each event, field by field, against the oldest one
// listed. Register writes happen between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module flash_chip_op_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                        kind;
        logic [fcos_pkg::CHIP_W-1:0] chip;
        logic [fcos_pkg::OP_W-1:0]   op;
        logic [fcos_pkg::TAG_W-1:0]  tag;
    } t_sched_item;

    typedef struct {
        logic [fcos_pkg::OP_W-1:0]  op;
        logic [fcos_pkg::TAG_W-1:0] tag;
    } t_op_entry;

    typedef struct {
        fcos_pkg::t_event ev;
        logic             last;
    } t_due_event;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_WAIT = 40;

    logic i_clk;
    logic i_rst_n;

    fcos_in_if  in_ch ();
    fcos_out_if out_ch ();
    fcos_cfg_if cfg_ch ();

    flash_chip_op_scheduler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // model state
    logic [fcos_pkg::LAT_W-1:0]  lat_r [3];
    logic [fcos_pkg::LIM_W-1:0]  qlimit_r;
    logic [fcos_pkg::TIME_W-1:0] now_us;
    logic                        model_busy [fcos_pkg::CHIPS];
    logic [fcos_pkg::TIME_W-1:0] wake_at [fcos_pkg::CHIPS];
    t_op_entry                   running [fcos_pkg::CHIPS];
    t_op_entry                   chip_fifo [fcos_pkg::CHIPS][$];

    t_sched_item pending_items [$];
    t_due_event  events_due [$];
    int          mismatches;
    int          idle_cycles;
    int          send_gap;
    int          stall_gap;
    int          sent_count;
    logic        gapless;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic void note_event(input logic [1:0] ev,
                                       input logic [fcos_pkg::CHIP_W-1:0] chip,
                                       input t_op_entry e);
        t_due_event d;
        d.ev.ev   = ev;
        d.ev.chip = chip;
        d.ev.op   = e.op;
        d.ev.tag  = e.tag;
        d.ev.ts   = now_us;
        d.last    = 1'b0;
        events_due.push_back(d);
    endfunction

    function automatic void schedule_step(input t_sched_item it);
        int        n;
        int        lim;
        t_op_entry e;
        e.op  = it.op;
        e.tag = it.tag;
        n = 0;
        if (it.kind == fcos_pkg::KIND_ISSUE) begin
            lim = (qlimit_r < 1) ? 1 : ((qlimit_r > fcos_pkg::QUEUE_DEPTH) ?
                  fcos_pkg::QUEUE_DEPTH : int'(qlimit_r));
            if (it.op == fcos_pkg::OP_BAD || chip_fifo[it.chip].size() >= lim) begin
                note_event(fcos_pkg::EV_REJECTED, it.chip, e);
            end else begin
                chip_fifo[it.chip].push_back(e);
                note_event(fcos_pkg::EV_ACCEPTED, it.chip, e);
            end
            n = 1;
        end else begin
            now_us = now_us + 1'b1;
            for (int c = 0; c < fcos_pkg::CHIPS && n < 16; c++) begin
                if (model_busy[c] && (now_us - wake_at[c]) < 32'h8000_0000) begin
                    model_busy[c] = 1'b0;
                    note_event(fcos_pkg::EV_FINISHED, c[fcos_pkg::CHIP_W-1:0], running[c]);
                    n++;
                end
            end
            for (int c = 0; c < fcos_pkg::CHIPS && n < 16; c++) begin
                if (!model_busy[c] && chip_fifo[c].size() > 0) begin
                    e = chip_fifo[c].pop_front();
                    running[c]    = e;
                    model_busy[c] = 1'b1;
                    wake_at[c]    = now_us + fcos_pkg::TIME_W'(
                                    (e.op == fcos_pkg::OP_READ) ? lat_r[0] :
                                    (e.op == fcos_pkg::OP_PROGRAM) ? lat_r[1] : lat_r[2]);
                    note_event(fcos_pkg::EV_STARTED, c[fcos_pkg::CHIP_W-1:0], e);
                    n++;
                end
            end
        end
        if (n > 0) events_due[events_due.size()-1].last = 1'b1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_sched_item it;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.kind      <= fcos_pkg::KIND_ISSUE;
            in_ch.chip      <= '0;
            in_ch.operation <= fcos_pkg::OP_READ;
            in_ch.tag       <= '0;
            send_gap        <= 0;
            sent_count      <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                it.kind = in_ch.kind;
                it.chip = in_ch.chip;
                it.op   = in_ch.operation;
                it.tag  = in_ch.tag;
                schedule_step(it);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap    <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.kind      <= it.kind;
                    in_ch.chip      <= it.chip;
                    in_ch.operation <= it.op;
                    in_ch.tag       <= it.tag;
                    sent_count      <= sent_count + 1;
                    send_gap        <= gapless ? 0 : int'($urandom_range(0, 7));
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_due_event d;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_gap    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (events_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event ev=%0d chip=%0d op=%0d tag=%h ts=%0d",
                                 out_ch.event_res, out_ch.chip_out, out_ch.operation_out,
                                 out_ch.tag_out, out_ch.time_stamp);
                end else begin
                    d = events_due.pop_front();
                    if (out_ch.event_res !== d.ev.ev || out_ch.chip_out !== d.ev.chip ||
                        out_ch.operation_out !== d.ev.op || out_ch.tag_out !== d.ev.tag ||
                        out_ch.time_stamp !== d.ev.ts || out_ch.last !== d.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp ev=%0d chip=%0d op=%0d tag=%h ts=%0d ",
                                      "last=%0b got ev=%0d chip=%0d op=%0d tag=%h ts=%0d ",
                                      "last=%0b"},
                                     d.ev.ev, d.ev.chip, d.ev.op, d.ev.tag, d.ev.ts, d.last,
                                     out_ch.event_res, out_ch.chip_out, out_ch.operation_out,
                                     out_ch.tag_out, out_ch.time_stamp, out_ch.last);
                    end
                end
                stall_gap    <= gapless ? 0 : int'($urandom_range(0, 7));
                out_ch.ready <= gapless;
            end else if (stall_gap > 0) begin
                stall_gap    <= stall_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || cfg_ch.valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL flash_chip_op_scheduler");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic kind, input int chip,
                            input logic [fcos_pkg::OP_W-1:0] op,
                            input logic [fcos_pkg::TAG_W-1:0] tag);
        t_sched_item it;
        it.kind = kind;
        it.chip = chip[fcos_pkg::CHIP_W-1:0];
        it.op   = op;
        it.tag  = tag;
        pending_items.push_back(it);
    endtask

    task automatic add_random(input int count, input int tick_pct);
        logic [fcos_pkg::OP_W-1:0] op;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                add_item(fcos_pkg::KIND_TICK, $urandom_range(0, 7),
                         fcos_pkg::OP_W'($urandom_range(0, 3)),
                         fcos_pkg::TAG_W'($urandom));
            end else begin
                op = ($urandom_range(0, 11) == 0) ? fcos_pkg::OP_BAD
                     : fcos_pkg::OP_W'($urandom_range(0, 2));
                add_item(fcos_pkg::KIND_ISSUE, $urandom_range(0, 7), op,
                         fcos_pkg::TAG_W'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_ch.valid || events_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [fcos_pkg::LAT_W-1:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index == fcos_pkg::REG_QLIMIT) qlimit_r = data[fcos_pkg::LIM_W-1:0];
        else lat_r[index] = data;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(input int rd, input int pg, input int er, input int lim);
        write_reg(fcos_pkg::REG_READ_LAT, fcos_pkg::LAT_W'(rd));
        write_reg(fcos_pkg::REG_PROG_LAT, fcos_pkg::LAT_W'(pg));
        write_reg(fcos_pkg::REG_ERASE_LAT, fcos_pkg::LAT_W'(er));
        write_reg(fcos_pkg::REG_QLIMIT, fcos_pkg::LAT_W'(lim));
    endtask

    initial begin
        mismatches   = 0;
        gapless      = 1'b0;
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = fcos_pkg::REG_READ_LAT;
        cfg_ch.data  = '0;
        lat_r[0] = fcos_pkg::LAT_W'(50);
        lat_r[1] = fcos_pkg::LAT_W'(500);
        lat_r[2] = fcos_pkg::LAT_W'(3000);
        qlimit_r = fcos_pkg::LIM_W'(16);
        now_us   = '0;
        for (int c = 0; c < fcos_pkg::CHIPS; c++) begin
            model_busy[c] = 1'b0;
            wake_at[c]    = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset, reads finish after 50 ticks
        add_item(fcos_pkg::KIND_ISSUE, 0, fcos_pkg::OP_READ, 16'h1234);
        add_item(fcos_pkg::KIND_ISSUE, 1, fcos_pkg::OP_PROGRAM, 16'h0001);
        add_random(70, 80);
        wait_idle();

        // directed: limit of one, short latencies, field extremes
        set_regs(0, 1, 3, 1);
        add_item(fcos_pkg::KIND_ISSUE, 0, fcos_pkg::OP_READ, 16'h0000);
        add_item(fcos_pkg::KIND_ISSUE, 0, fcos_pkg::OP_PROGRAM, 16'hffff);
        add_item(fcos_pkg::KIND_ISSUE, 7, fcos_pkg::OP_ERASE, 16'hffff);
        add_item(fcos_pkg::KIND_ISSUE, 3, fcos_pkg::OP_BAD, 16'h5a5a);
        add_item(fcos_pkg::KIND_ISSUE, 5, fcos_pkg::OP_PROGRAM, 16'ha5a5);
        for (int k = 0; k < 6; k++) add_item(fcos_pkg::KIND_TICK, 0, fcos_pkg::OP_READ, 16'h0);
        for (int c = 0; c < fcos_pkg::CHIPS; c++)
            add_item(fcos_pkg::KIND_ISSUE, c, fcos_pkg::OP_READ, fcos_pkg::TAG_W'(c));
        for (int k = 0; k < 3; k++) add_item(fcos_pkg::KIND_TICK, 7, fcos_pkg::OP_BAD, 16'hffff);
        wait_idle();

        // limit zero clamps to one
        set_regs(2, 0, 5, 0);
        add_random(40, 30);
        wait_idle();

        // all chips busy at once, then the bulk of random traffic
        set_regs(4, 4, 4, 31);
        for (int c = 0; c < fcos_pkg::CHIPS; c++) begin
            add_item(fcos_pkg::KIND_ISSUE, c, fcos_pkg::OP_ERASE, fcos_pkg::TAG_W'($urandom));
            add_item(fcos_pkg::KIND_ISSUE, c, fcos_pkg::OP_READ, fcos_pkg::TAG_W'($urandom));
        end
        for (int k = 0; k < 6; k++) add_item(fcos_pkg::KIND_TICK, 0, fcos_pkg::OP_READ, 16'h0);
        add_random(100, 35);
        wait_idle();

        set_regs($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 12),
                 $urandom_range(2, 16));
        gapless = 1'b1;
        add_random(60, 40);
        wait_idle();
        gapless = 1'b0;
        add_random(80, 40);
        wait_idle();

        // longest latencies
        set_regs(20'hfffff, 20'hfffff, 20'hfffff, 16);
        add_random(30, 40);
        wait_idle();

        if (mismatches == 0 && events_due.size() == 0) begin
            $display("PASS flash_chip_op_scheduler");
        end else begin
            $display("FAIL flash_chip_op_scheduler");
        end
        $finish;
    end

endmodule

// ----- flash_chip_op_scheduler.f -----
design/fcos_pkg.sv
design/fcos_if.sv
design/fcos_ctrl.sv
design/fcos_dp.sv
design/flash_chip_op_scheduler.sv
tb/flash_chip_op_scheduler_test.sv
